### design/efc_pkg.sv
// Shared constants, types and helpers of the envelope frame checker.
// Used by efc_front, efc_queue, efc_back and envelope_frame_checker_core.
// No dependencies.
package efc_pkg;

	// Largest envelope accepted, in bytes, header included.
	localparam int MAX_ENVELOPE_BYTES = 4096;

	// The byte count saturates one above the maximum.
	localparam int POS_W = $clog2(MAX_ENVELOPE_BYTES + 2);
	localparam int LEN_W = 12;
	localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int KIND_W = 8;
	localparam int OPID_W = 64;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ENVELOPE_BYTES);
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_ENVELOPE_BYTES + 1);

	// Header layout.
	localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(16);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
	localparam logic [POS_W-1:0] POS_KIND = POS_W'(5);
	localparam logic [POS_W-1:0] POS_RSV0 = POS_W'(6);
	localparam logic [POS_W-1:0] POS_RSV1 = POS_W'(7);
	localparam logic [7:0] HDR_VERSION = 8'h01;

	localparam logic [CMP_W-1:0] STATUS_PAYLOAD = CMP_W'(16);
	localparam logic [CMP_W-1:0] BOARD_PAYLOAD = CMP_W'(32);

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_KIND_BINDING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND_FABRIC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KIND_STATUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KIND_BOARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BINDING_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BINDING_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FABRIC_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FABRIC_MAX = 3'd7;

	// Verdict codes.
	localparam logic [1:0] VERDICT_OK = 2'd0;
	localparam logic [1:0] VERDICT_LEN_ERR = 2'd1;
	localparam logic [1:0] VERDICT_STRUCT_ERR = 2'd2;

	// Request queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0] kind_binding;
		logic [KIND_W-1:0] kind_fabric;
		logic [KIND_W-1:0] kind_status;
		logic [KIND_W-1:0] kind_board;
		logic [LEN_W-1:0] binding_min;
		logic [LEN_W-1:0] binding_max;
		logic [LEN_W-1:0] fabric_min;
		logic [LEN_W-1:0] fabric_max;
	} cfg_t;

	// One request from the front: a payload byte, a verdict, or both.
	typedef struct packed {
		logic payload;
		logic [7:0] data;
		logic last;
		logic len_err;
		logic hdr_bad;
		logic [POS_W-1:0] total;
		logic [KIND_W-1:0] kind;
		logic [OPID_W-1:0] opid;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Magic bytes of the header, in order.
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h4E;
			2'd1: m = 8'h56;
			2'd2: m = 8'h42;
			2'd3: m = 8'h31;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

### design/efc_front.sv
// Front part of the envelope frame checker: takes bytes, tracks position,
// checks the header and issues requests to the queue. Depends on efc_pkg.
module efc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	input efc_pkg::q_status_t q_status,
	output logic push,
	output efc_pkg::entry_t entry
);

	logic [efc_pkg::POS_W-1:0] pos_q;
	logic hdr_bad_q;
	logic [efc_pkg::KIND_W-1:0] kind_q;
	logic [efc_pkg::OPID_W-1:0] opid_q;

	logic is_payload;
	logic byte_bad;
	logic hdr_bad_n;
	logic [efc_pkg::KIND_W-1:0] kind_n;
	logic [efc_pkg::OPID_W-1:0] opid_n;
	logic [efc_pkg::POS_W-1:0] total;
	logic accept;

	assign in_ready = !q_status.full;
	assign accept = in_valid && in_ready;

	always_comb begin
		is_payload = (pos_q >= efc_pkg::HDR_BYTES);
		byte_bad = 1'b0;
		kind_n = kind_q;
		opid_n = opid_q;
		if (!is_payload) begin
			if (pos_q < efc_pkg::POS_VERSION) begin
				byte_bad = (data_byte != efc_pkg::magic_byte(pos_q[1:0]));
			end else if (pos_q == efc_pkg::POS_VERSION) begin
				byte_bad = (data_byte != efc_pkg::HDR_VERSION);
			end else if (pos_q == efc_pkg::POS_KIND) begin
				kind_n = data_byte;
			end else if (pos_q == efc_pkg::POS_RSV0 || pos_q == efc_pkg::POS_RSV1) begin
				byte_bad = (data_byte != 8'h00);
			end else begin
				opid_n = {opid_q[efc_pkg::OPID_W-9:0], data_byte};
			end
		end
		hdr_bad_n = hdr_bad_q | byte_bad;
		total = (pos_q == efc_pkg::POS_SAT) ? pos_q : pos_q + efc_pkg::POS_W'(1);
	end

	always_comb begin
		push = accept && (is_payload || last_byte);
		entry.payload = is_payload;
		entry.data = is_payload ? data_byte : 8'h00;
		entry.last = last_byte;
		entry.len_err = (total < efc_pkg::HDR_BYTES) || (total > efc_pkg::POS_MAX);
		entry.hdr_bad = hdr_bad_n;
		entry.total = total;
		entry.kind = kind_n;
		entry.opid = opid_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_bad_q <= 1'b0;
			kind_q <= '0;
			opid_q <= '0;
		end else if (accept) begin
			pos_q <= last_byte ? '0 : total;
			hdr_bad_q <= last_byte ? 1'b0 : hdr_bad_n;
			kind_q <= kind_n;
			opid_q <= opid_n;
		end
	end

endmodule

### design/efc_queue.sv
// Short request queue between the front and back parts of the checker.
// Depends on efc_pkg for the entry type and depth.
module efc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input efc_pkg::entry_t push_entry,
	input logic pop,
	output efc_pkg::entry_t head,
	output efc_pkg::q_status_t status
);

	efc_pkg::entry_t mem_q [efc_pkg::QUEUE_DEPTH];
	logic [efc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [efc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [efc_pkg::QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	function automatic logic [efc_pkg::QPTR_W-1:0] ptr_next(
		input logic [efc_pkg::QPTR_W-1:0] p);
		logic [efc_pkg::QPTR_W-1:0] n;
		if (p == efc_pkg::QPTR_W'(efc_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + efc_pkg::QPTR_W'(1);
		end
		return n;
	endfunction

	assign status.full = (count_q == efc_pkg::QCNT_W'(efc_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + efc_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - efc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### design/efc_back.sv
// Back part of the checker: takes requests from the queue, forms the
// verdict and holds the result register. Depends on efc_pkg.
module efc_back (
	input logic clk,
	input logic arst_n,
	input efc_pkg::entry_t head,
	input efc_pkg::q_status_t q_status,
	input efc_pkg::cfg_t cfg,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic payload_valid,
	output logic [7:0] payload_byte,
	output logic verdict_valid,
	output logic [1:0] verdict_code,
	output logic [efc_pkg::KIND_W-1:0] frame_kind,
	output logic [efc_pkg::OPID_W-1:0] frame_opid
);

	logic out_valid_q;
	logic payload_valid_q;
	logic [7:0] payload_byte_q;
	logic verdict_valid_q;
	logic [1:0] verdict_code_q;
	logic [efc_pkg::KIND_W-1:0] frame_kind_q;
	logic [efc_pkg::OPID_W-1:0] frame_opid_q;

	logic [efc_pkg::CMP_W-1:0] plen;
	logic suits;
	logic [1:0] code;

	always_comb begin
		plen = efc_pkg::CMP_W'(head.total) - efc_pkg::CMP_W'(efc_pkg::HDR_BYTES);
		// Kinds are matched in register order; the first match decides.
		if (head.kind == cfg.kind_binding) begin
			suits = (plen >= efc_pkg::CMP_W'(cfg.binding_min)) &&
				(plen <= efc_pkg::CMP_W'(cfg.binding_max));
		end else if (head.kind == cfg.kind_fabric) begin
			suits = (plen >= efc_pkg::CMP_W'(cfg.fabric_min)) &&
				(plen <= efc_pkg::CMP_W'(cfg.fabric_max));
		end else if (head.kind == cfg.kind_status) begin
			suits = (plen == efc_pkg::STATUS_PAYLOAD);
		end else if (head.kind == cfg.kind_board) begin
			suits = (plen == efc_pkg::BOARD_PAYLOAD);
		end else begin
			suits = 1'b0;
		end
		if (head.len_err) begin
			code = efc_pkg::VERDICT_LEN_ERR;
		end else if (head.hdr_bad || head.opid == '0 || !suits) begin
			code = efc_pkg::VERDICT_STRUCT_ERR;
		end else begin
			code = efc_pkg::VERDICT_OK;
		end
	end

	assign pop = !q_status.empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			payload_valid_q <= head.payload;
			payload_byte_q <= head.data;
			verdict_valid_q <= head.last;
			if (head.last) begin
				verdict_code_q <= code;
			end else begin
				verdict_code_q <= efc_pkg::VERDICT_OK;
			end
			if (head.last && code == efc_pkg::VERDICT_OK) begin
				frame_kind_q <= head.kind;
				frame_opid_q <= head.opid;
			end else begin
				frame_kind_q <= '0;
				frame_opid_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign payload_valid = payload_valid_q;
	assign payload_byte = payload_byte_q;
	assign verdict_valid = verdict_valid_q;
	assign verdict_code = verdict_code_q;
	assign frame_kind = frame_kind_q;
	assign frame_opid = frame_opid_q;

endmodule

### design/envelope_frame_checker_core.sv
// Envelope frame checker, top level: configuration registers, front, queue, back.
// An accepted payload or last byte is registered in the request queue and then in the
// back's result register. Throughput: one byte per cycle while the queue is not full, set
// by the single-byte front stage. The four-entry request queue lets front and back stall on their own.
// Reset (arst_n low, asynchronous) clears control state and loads register defaults.
// No clearing pass is needed after reset. Depends on efc_pkg and the three submodules.
module envelope_frame_checker_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic payload_valid,
	output logic [7:0] payload_byte,
	output logic verdict_valid,
	output logic [1:0] verdict_code,
	output logic [efc_pkg::KIND_W-1:0] frame_kind,
	output logic [efc_pkg::OPID_W-1:0] frame_opid,
	input logic cfg_we,
	input logic [efc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [efc_pkg::CFG_DATA_W-1:0] cfg_data
);

	efc_pkg::cfg_t cfg_q;
	efc_pkg::entry_t push_entry;
	efc_pkg::entry_t head;
	efc_pkg::q_status_t q_status;
	logic push;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind_binding <= 8'd1;
			cfg_q.kind_fabric <= 8'd2;
			cfg_q.kind_status <= 8'd3;
			cfg_q.kind_board <= 8'd4;
			cfg_q.binding_min <= 12'd1;
			cfg_q.binding_max <= 12'd4080;
			cfg_q.fabric_min <= 12'd1;
			cfg_q.fabric_max <= 12'd4080;
		end else if (cfg_we) begin
			case (cfg_index)
				efc_pkg::REG_KIND_BINDING: cfg_q.kind_binding <= cfg_data[7:0];
				efc_pkg::REG_KIND_FABRIC: cfg_q.kind_fabric <= cfg_data[7:0];
				efc_pkg::REG_KIND_STATUS: cfg_q.kind_status <= cfg_data[7:0];
				efc_pkg::REG_KIND_BOARD: cfg_q.kind_board <= cfg_data[7:0];
				efc_pkg::REG_BINDING_MIN: cfg_q.binding_min <= cfg_data;
				efc_pkg::REG_BINDING_MAX: cfg_q.binding_max <= cfg_data;
				efc_pkg::REG_FABRIC_MIN: cfg_q.fabric_min <= cfg_data;
				efc_pkg::REG_FABRIC_MAX: cfg_q.fabric_max <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	efc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.q_status(q_status),
		.push(push),
		.entry(push_entry)
	);

	efc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	efc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.cfg(cfg_q),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.verdict_valid(verdict_valid),
		.verdict_code(verdict_code),
		.frame_kind(frame_kind),
		.frame_opid(frame_opid)
	);

	// Every result carries a payload byte, a verdict, or both.
	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_valid || verdict_valid))
		else $error("result with neither payload nor verdict");

	// A result without a payload byte shows a zero byte.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !payload_valid) |-> (payload_byte == 8'h00))
		else $error("payload byte not zero without payload");

	// A failed verdict hides kind and operation id.
	a_fail_clears_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict_code != efc_pkg::VERDICT_OK) |->
		(frame_kind == '0 && frame_opid == '0))
		else $error("kind or operation id shown with failed verdict");

	// An ok verdict always carries a nonzero operation id.
	a_ok_has_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict_valid && verdict_code == efc_pkg::VERDICT_OK) |->
		(frame_opid != '0))
		else $error("ok verdict with zero operation id");

endmodule
